// ===== rtl/assert_macros.svh =====
// Assertion macros used by the codec RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ===== rtl/hkc_pkg.sv =====
package hkc_pkg;

    localparam int SYM_COUNT    = 258;
    localparam int SYM_W        = 9;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int MAX_CODE_LEN = 32;

    localparam logic [SYM_W-1:0] SYM_LF    = 9'd256;
    localparam logic [SYM_W-1:0] SYM_SPACE = 9'd257;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_DECODE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_CODE   = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_BAD_CODE  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEP   = 8'h58;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Lookup token that travels down the row of table cells.
    typedef struct packed {
        logic              valid;
        logic              enc;
        logic              hit;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } token_t;

    // Table write broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } table_wr_t;

    function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] mask;
        if (len >= LEN_W'(CODE_W))
        begin
            mask = '1;
        end
        else
        begin
            mask = (CODE_W'(1) << len) - CODE_W'(1);
        end
        return mask;
    endfunction

    function automatic logic [SYM_W-1:0] map_symbol(input logic [7:0] ch);
        logic [SYM_W-1:0] sym;
        if (ch == CH_LF)
        begin
            sym = SYM_LF;
        end
        else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF
                 || ch == CH_CR)
        begin
            sym = SYM_SPACE;
        end
        else
        begin
            sym = {1'b0, ch};
        end
        return sym;
    endfunction

endpackage

// ===== rtl/hkc_cell.sv =====
module hkc_cell
    import hkc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SYM_W-1:0] cell_index,
    input  table_wr_t        wr,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [CODE_W-1:0] code_reg;
    logic [LEN_W-1:0]  len_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              wr_hit;

    assign wr_hit = wr.en && (wr.sym == cell_index);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.enc)
        begin
            if (tok_in.sym == cell_index)
            begin
                tok_next.hit  = (len_reg != '0);
                tok_next.code = code_reg;
                tok_next.len  = len_reg;
            end
        end
        else if (!tok_in.hit && len_reg != '0 && len_reg == tok_in.len
                 && code_reg == tok_in.code)
        begin
            // The first matching cell in the row is the lowest symbol.
            tok_next.hit = 1'b1;
            tok_next.sym = cell_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                len_reg <= wr.len;
            end
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            code_reg <= wr.code;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/hkc_chain.sv =====
module hkc_chain
    import hkc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  table_wr_t wr,
    input  token_t    tok_in,
    output token_t    tok_out
);

    token_t link [0:SYM_COUNT];

    assign link[0] = tok_in;

    for (genvar i = 0; i < SYM_COUNT; i++)
    begin : g_cell
        hkc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (SYM_W'(i)),
            .wr         (wr),
            .tok_in     (link[i]),
            .tok_out    (link[i+1])
        );
    end

    assign tok_out = link[SYM_COUNT];

endmodule

// ===== rtl/huffman_table_text_codec.sv =====
// Table-driven prefix-code codec for text.
// Input channel (in_valid/in_ready) takes one beat per item: a table write,
// a byte to encode, or one coded character to decode. Output channel
// (out_valid/out_ready) gives one beat per result character with last and
// status. Table writes and decode characters other than 'X' produce nothing.
// An encode, or a decode 'X' with a clean gathered code, sends a lookup
// token down a row of 258 table cells, one cell per cycle; an encode with a
// code then gives its code characters and 'X' at one beat per cycle while
// out_ready is high. A decode 'X' after a bad character or an over-long code
// gives its error beat in the cycle after acceptance. One item is in work
// at a time: in_ready is low from the accepted lookup until its last beat
// is taken. A stalled receiver holds the current beat unchanged.
// Reset clears every table entry and the gathered decode code.
`include "assert_macros.svh"

module huffman_table_text_codec
    import hkc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [SYM_W-1:0]  table_symbol,
    input  logic [CODE_W-1:0] table_code,
    input  logic [LEN_W-1:0]  table_code_length,
    input  logic [7:0]        in_char,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              last,
    output logic [1:0]        status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CODE_W-1:0] gath_bits_reg, gath_bits_next;
    logic [LEN_W-1:0]  gath_count_reg, gath_count_next;
    logic              gath_fault_reg, gath_fault_next;
    logic [CODE_W-1:0] emit_bits_reg, emit_bits_next;
    logic [LEN_W-1:0]  emit_left_reg, emit_left_next;
    logic [7:0]        emit_char_reg, emit_char_next;
    logic [1:0]        emit_status_reg, emit_status_next;

    logic      accept;
    table_wr_t wr;
    token_t    launch;
    token_t    result;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign wr.en   = accept && (action == ACT_WRITE)
                     && (table_code_length <= LEN_W'(MAX_CODE_LEN));
    assign wr.sym  = table_symbol;
    assign wr.code = table_code & code_mask(table_code_length);
    assign wr.len  = table_code_length;

    hkc_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .tok_in  (launch),
        .tok_out (result)
    );

    always_comb
    begin
        state_next       = state_reg;
        gath_bits_next   = gath_bits_reg;
        gath_count_next  = gath_count_reg;
        gath_fault_next  = gath_fault_reg;
        emit_bits_next   = emit_bits_reg;
        emit_left_next   = emit_left_reg;
        emit_char_next   = emit_char_reg;
        emit_status_next = emit_status_reg;

        launch       = '0;
        launch.sym   = map_symbol(in_char);
        launch.enc   = (action == ACT_ENCODE);
        launch.code  = gath_bits_reg;
        launch.len   = gath_count_reg;
        launch.valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_ENCODE)
                begin
                    launch.valid = 1'b1;
                    state_next   = ST_SEARCH;
                end
                else if (accept && action == ACT_DECODE)
                begin
                    if (in_char == CH_ZERO || in_char == CH_ONE)
                    begin
                        if (gath_count_reg >= LEN_W'(MAX_CODE_LEN))
                        begin
                            gath_fault_next = 1'b1;
                        end
                        else
                        begin
                            gath_bits_next  = {gath_bits_reg[CODE_W-2:0], in_char[0]};
                            gath_count_next = gath_count_reg + LEN_W'(1);
                        end
                    end
                    else if (in_char != CH_SEP)
                    begin
                        gath_fault_next = 1'b1;
                    end
                    else
                    begin
                        if (gath_fault_reg)
                        begin
                            emit_status_next = STAT_BAD_CODE;
                            emit_left_next   = '0;
                            state_next       = ST_EMIT;
                        end
                        else
                        begin
                            launch.valid = 1'b1;
                            state_next   = ST_SEARCH;
                        end
                        gath_bits_next  = '0;
                        gath_count_next = '0;
                        gath_fault_next = 1'b0;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (result.valid)
                begin
                    state_next     = ST_EMIT;
                    emit_left_next = '0;
                    if (result.enc)
                    begin
                        emit_status_next = result.hit ? STAT_OK : STAT_NO_CODE;
                        emit_left_next   = result.hit ? result.len : '0;
                        emit_bits_next   = result.code << (LEN_W'(CODE_W) - result.len);
                        emit_char_next   = CH_SEP;
                    end
                    else
                    begin
                        emit_status_next = result.hit ? STAT_OK : STAT_NOT_FOUND;
                        if (result.sym == SYM_LF)
                        begin
                            emit_char_next = CH_LF;
                        end
                        else if (result.sym == SYM_SPACE)
                        begin
                            emit_char_next = CH_SPACE;
                        end
                        else
                        begin
                            emit_char_next = result.sym[7:0];
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (emit_status_reg == STAT_OK && emit_left_reg != '0)
                    begin
                        emit_left_next = emit_left_reg - LEN_W'(1);
                        emit_bits_next = emit_bits_reg << 1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gath_bits_reg   <= '0;
            gath_count_reg  <= '0;
            gath_fault_reg  <= 1'b0;
            emit_bits_reg   <= '0;
            emit_left_reg   <= '0;
            emit_char_reg   <= '0;
            emit_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg       <= state_next;
            gath_bits_reg   <= gath_bits_next;
            gath_count_reg  <= gath_count_next;
            gath_fault_reg  <= gath_fault_next;
            emit_bits_reg   <= emit_bits_next;
            emit_left_reg   <= emit_left_next;
            emit_char_reg   <= emit_char_next;
            emit_status_reg <= emit_status_next;
        end
    end

    assign out_valid = (state_reg == ST_EMIT);
    assign status    = emit_status_reg;
    assign last      = (emit_status_reg != STAT_OK) || (emit_left_reg == '0);

    always_comb
    begin
        if (emit_status_reg != STAT_OK)
        begin
            out_char = '0;
        end
        else if (emit_left_reg != '0)
        begin
            out_char = CH_ZERO | {7'd0, emit_bits_reg[CODE_W-1]};
        end
        else
        begin
            out_char = emit_char_reg;
        end
    end

    `ASSERT_IMP(a_token_only_in_search, result.valid, state_reg == ST_SEARCH)
    `ASSERT_IMP(a_code_beats_are_ok, out_valid && emit_left_reg != '0, status == STAT_OK)
    `ASSERT_NXT(a_encode_starts_search, accept && action == ACT_ENCODE, state_reg == ST_SEARCH)
    `ASSERT_IMP(a_gather_in_range, 1'b1, gath_count_reg <= LEN_W'(MAX_CODE_LEN))

endmodule
